### rtl/bpc_pkg.sv
package bpc_pkg;

    localparam logic [2:0] ADDR_A1 = 3'd0;
    localparam logic [2:0] ADDR_A2 = 3'd1;
    localparam logic [2:0] ADDR_A3 = 3'd2;
    localparam logic [2:0] ADDR_A4 = 3'd3;
    localparam logic [2:0] ADDR_A5 = 3'd4;
    localparam logic [2:0] ADDR_A6 = 3'd5;
    localparam logic [2:0] ADDR_BP = 3'd6;
    localparam logic [2:0] ADDR_MP = 3'd7;

    localparam logic [15:0] RST_A1 = 16'd408;
    localparam logic [15:0] RST_A2 = 16'hFFB8;
    localparam logic [15:0] RST_A3 = 16'hC7D1;
    localparam logic [15:0] RST_A4 = 16'd32741;
    localparam logic [15:0] RST_A5 = 16'd32757;
    localparam logic [15:0] RST_A6 = 16'd23153;
    localparam logic [31:0] RST_BP = 32'd405667844;
    localparam logic [31:0] RST_MP = 32'd3724086068;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] P_SCALE   = 32'd50000;
    localparam logic [31:0] K_SQ      = 32'd3038;
    localparam logic [31:0] K_LIN     = 32'hFFFFE343;
    localparam logic [31:0] K_OFS     = 32'd3791;

    // divider request and result
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

### rtl/bpc_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module bpc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bpc_pkg::div_req_t  req,
    output bpc_pkg::div_rsp_t  rsp
);

    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};

    // one shift-subtract step each cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held two cycles");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < 6'd32)
        else $error("divider count out of range");

endmodule

### rtl/barometric_pressure_compensation.sv
// A temperature or a pressure request runs its sequencer steps through the divider; a zero
// divisor skips the divider. One request at a time, in_ready low while the sequencer
// runs: a new request can be taken in the cycle after the result loads, and the load
// waits while a stalled result holds the output register. The divider is bit-serial
// and one 32x32 multiplier is shared by the steps.
// Reset: calibration registers load factory values, b5 term clears, no result pending.
module barometric_pressure_compensation (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  logic [23:0]  raw_reading,
    input  logic [1:0]   oversampling,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         is_pressure,
    output logic signed [31:0] value,
    output logic         div_fault
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T1   = 5'd1;
    localparam logic [4:0] S_T2   = 5'd2;
    localparam logic [4:0] S_TDW  = 5'd3;
    localparam logic [4:0] S_T3   = 5'd4;
    localparam logic [4:0] S_P1   = 5'd5;
    localparam logic [4:0] S_P2   = 5'd6;
    localparam logic [4:0] S_P3   = 5'd7;
    localparam logic [4:0] S_P4   = 5'd8;
    localparam logic [4:0] S_P5   = 5'd9;
    localparam logic [4:0] S_P6   = 5'd10;
    localparam logic [4:0] S_P8   = 5'd12;
    localparam logic [4:0] S_P9   = 5'd13;
    localparam logic [4:0] S_PDW  = 5'd14;
    localparam logic [4:0] S_Q1   = 5'd15;
    localparam logic [4:0] S_Q2   = 5'd16;
    localparam logic [4:0] S_Q3   = 5'd17;
    localparam logic [4:0] S_Q4   = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    logic [15:0] a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    logic [31:0] bp_reg, mp_reg;
    logic [31:0] b5_reg;

    logic [4:0]  state_reg;
    logic        kind_reg;
    logic [1:0]  oss_reg;
    logic [23:0] raw_reg;
    logic [31:0] x1_reg, b6_reg, sq_reg, acc_reg, b3_reg, b4_reg, p_reg;
    logic        neg_reg, halve_reg;
    logic [31:0] prod_reg;

    logic        ov_reg, pres_reg, flt_reg;
    logic [31:0] val_reg;
    logic        out_flt_reg;
    logic [31:0] out_val_reg;

    logic        div_start_reg;
    logic [31:0] div_num_reg, div_den_reg;

    logic [2:0]  reg_idx;
    logic        wr_en;
    logic [31:0] mul_a, mul_b, prod;
    logic        div_go;
    logic        out_load;
    bpc_pkg::div_req_t dreq;
    bpc_pkg::div_rsp_t drsp;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            bpc_pkg::ADDR_A1: prdata = {16'd0, a1_reg};
            bpc_pkg::ADDR_A2: prdata = {16'd0, a2_reg};
            bpc_pkg::ADDR_A3: prdata = {16'd0, a3_reg};
            bpc_pkg::ADDR_A4: prdata = {16'd0, a4_reg};
            bpc_pkg::ADDR_A5: prdata = {16'd0, a5_reg};
            bpc_pkg::ADDR_A6: prdata = {16'd0, a6_reg};
            bpc_pkg::ADDR_BP: prdata = bp_reg;
            default:          prdata = mp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= bpc_pkg::RST_A1;
            a2_reg <= bpc_pkg::RST_A2;
            a3_reg <= bpc_pkg::RST_A3;
            a4_reg <= bpc_pkg::RST_A4;
            a5_reg <= bpc_pkg::RST_A5;
            a6_reg <= bpc_pkg::RST_A6;
            bp_reg <= bpc_pkg::RST_BP;
            mp_reg <= bpc_pkg::RST_MP;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bpc_pkg::ADDR_A1: a1_reg <= pwdata[15:0];
                bpc_pkg::ADDR_A2: a2_reg <= pwdata[15:0];
                bpc_pkg::ADDR_A3: a3_reg <= pwdata[15:0];
                bpc_pkg::ADDR_A4: a4_reg <= pwdata[15:0];
                bpc_pkg::ADDR_A5: a5_reg <= pwdata[15:0];
                bpc_pkg::ADDR_A6: a6_reg <= pwdata[15:0];
                bpc_pkg::ADDR_BP: bp_reg <= pwdata;
                default:          mp_reg <= pwdata;
            endcase
        end
    end

    // helpers
    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        asr = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] neg32(input logic [31:0] x);
        neg32 = 32'd0 - x;
    endfunction

    logic [31:0] tden, tnum, up, pnum;
    assign tden = x1_reg + bpc_pkg::sx16(mp_reg[15:0]);
    assign tnum = bpc_pkg::sx16(mp_reg[31:16]) << 11;
    assign up   = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
    assign pnum = acc_reg[31] ? acc_reg : {acc_reg[30:0], 1'b0};

    // divider launch when the divisor is nonzero
    assign div_go = ((state_reg == S_T2) && (tden != 32'd0))
                 || ((state_reg == S_P9) && (b4_reg != 32'd0));

    // result moves to the output register once that is free
    assign out_load = (state_reg == S_OUT) && (!ov_reg || out_ready);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_T1: begin mul_a = {16'd0, raw_reg[15:0]} - {16'd0, a6_reg};
                        mul_b = {16'd0, a5_reg}; end
            S_P1: begin mul_a = b6_reg; mul_b = b6_reg; end
            S_P2: begin mul_a = bpc_pkg::sx16(bp_reg[15:0]); mul_b = sq_reg; end
            S_P3: begin mul_a = bpc_pkg::sx16(a2_reg); mul_b = b6_reg; end
            S_P4: begin mul_a = bpc_pkg::sx16(a3_reg); mul_b = b6_reg; end
            S_P5: begin mul_a = bpc_pkg::sx16(bp_reg[31:16]); mul_b = sq_reg; end
            S_P6: begin mul_a = {16'd0, a4_reg}; mul_b = acc_reg + 32'd32768; end
            S_P8: begin mul_a = up - b3_reg; mul_b = bpc_pkg::P_SCALE >> oss_reg; end
            S_Q1: begin mul_a = asr(p_reg, 5'd8); mul_b = asr(p_reg, 5'd8); end
            S_Q2: begin mul_a = prod_reg; mul_b = bpc_pkg::K_SQ; end
            S_Q3: begin mul_a = bpc_pkg::K_LIN; mul_b = p_reg; end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    assign in_ready = (state_reg == S_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            b5_reg        <= '0;
            ov_reg        <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_go;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        kind_reg <= kind;
                        raw_reg  <= raw_reading;
                        oss_reg  <= oversampling;
                        b6_reg   <= b5_reg - bpc_pkg::B6_OFFSET;
                        state_reg <= kind ? S_P1 : S_T1;
                    end
                end
                S_T1:
                begin
                    x1_reg <= asr(prod, 5'd15);
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    if (tden == 32'd0)
                    begin
                        flt_reg <= 1'b1;
                        val_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        neg_reg     <= tnum[31] ^ tden[31];
                        div_num_reg <= tnum[31] ? neg32(tnum) : tnum;
                        div_den_reg <= tden[31] ? neg32(tden) : tden;
                        state_reg   <= S_TDW;
                    end
                end
                S_TDW:
                begin
                    if (drsp.done)
                    begin
                        b5_reg <= x1_reg + (neg_reg ? neg32(drsp.quo) : drsp.quo);
                        state_reg <= S_T3;
                    end
                end
                S_T3:
                begin
                    flt_reg <= 1'b0;
                    val_reg <= asr(b5_reg + 32'd8, 5'd4);
                    state_reg <= S_OUT;
                end
                S_P1:
                begin
                    sq_reg <= asr(prod, 5'd12);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    acc_reg <= asr(prod, 5'd11);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    b3_reg <= asr((((bpc_pkg::sx16(a1_reg) << 2) + acc_reg
                                   + asr(prod, 5'd11)) << oss_reg) + 32'd2, 5'd2);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    acc_reg <= asr(prod, 5'd13);
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    acc_reg <= asr(acc_reg + asr(prod, 5'd16) + 32'd2, 5'd2);
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    b4_reg <= prod >> 15;
                    state_reg <= S_P8;
                end
                S_P8:
                begin
                    acc_reg <= prod;
                    state_reg <= S_P9;
                end
                S_P9:
                begin
                    if (b4_reg == 32'd0)
                    begin
                        flt_reg <= 1'b1;
                        val_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        halve_reg   <= acc_reg[31];
                        div_num_reg <= pnum;
                        div_den_reg <= b4_reg;
                        state_reg   <= S_PDW;
                    end
                end
                S_PDW:
                begin
                    if (drsp.done)
                    begin
                        p_reg <= halve_reg ? {drsp.quo[30:0], 1'b0} : drsp.quo;
                        state_reg <= S_Q1;
                    end
                end
                S_Q1:
                begin
                    prod_reg <= prod;
                    state_reg <= S_Q2;
                end
                S_Q2:
                begin
                    acc_reg <= asr(prod, 5'd16);
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    prod_reg <= asr(prod, 5'd16);
                    state_reg <= S_Q4;
                end
                S_Q4:
                begin
                    flt_reg <= 1'b0;
                    val_reg <= p_reg + asr(acc_reg + prod_reg + bpc_pkg::K_OFS, 5'd4);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        pres_reg    <= kind_reg;
                        out_val_reg <= val_reg;
                        out_flt_reg <= flt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign dreq = {div_start_reg, div_num_reg, div_den_reg};

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign out_valid   = ov_reg;
    assign is_pressure = pres_reg;
    assign value       = $signed(out_val_reg);
    assign div_fault   = out_flt_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_val_reg))
        else $error("result dropped while stalled");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_T1 || state_reg == S_P1))
        else $error("accepted request did not start");
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_fault) |-> out_val_reg == 32'd0)
        else $error("fault result not zero");

endmodule

### bench/barometric_pressure_compensation_test.sv
module barometric_pressure_compensation_test;

    typedef struct packed {
        logic        kind;
        logic [23:0] raw;
        logic [1:0]  oss;
    } reading_t;

    typedef struct packed {
        logic        is_p;
        logic [31:0] val;
        logic        fault;
    } calib_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         in_valid;
    logic         in_ready;
    logic         kind;
    logic [23:0]  raw_reading;
    logic [1:0]   oversampling;
    logic         out_valid;
    logic         out_ready;
    logic         is_pressure;
    logic signed [31:0] value;
    logic         div_fault;

    // shadow calibration and b5 term
    logic [15:0] sh_a1, sh_a2, sh_a3, sh_a4, sh_a5, sh_a6;
    logic [31:0] sh_bp, sh_mp, sh_b5;

    reading_t pending_readings[$];
    calib_t   expected_values[$];
    int       errors;
    int       hold_cnt;
    int       ready_hold;

    barometric_pressure_compensation i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .raw_reading(raw_reading), .oversampling(oversampling),
        .out_valid(out_valid), .out_ready(out_ready), .is_pressure(is_pressure),
        .value(value), .div_fault(div_fault)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // compensate one reading against the shadow calibration
    function automatic calib_t compensate(input reading_t rd);
        calib_t      res;
        logic [31:0] ut, mc, md, x1, x2, x3, den, q, mn, mdd;
        logic [31:0] up, b1, b2, ac1, ac2, ac3, b6, sq, b3, b4, b7, p;
        res.is_p = rd.kind;
        res.val = 32'd0;
        res.fault = 1'b0;
        if (!rd.kind)
        begin
            ut = {16'd0, rd.raw[15:0]};
            mc = sext16(sh_mp[31:16]);
            md = sext16(sh_mp[15:0]);
            x1 = asr32((ut - {16'd0, sh_a6}) * {16'd0, sh_a5}, 15);
            den = x1 + md;
            if (den == 32'd0)
                res.fault = 1'b1;
            else
            begin
                // truncating signed divide
                x2 = mc << 11;
                mn = x2[31] ? -x2 : x2;
                mdd = den[31] ? -den : den;
                q = mn / mdd;
                if (x2[31] != den[31])
                    q = -q;
                sh_b5 = x1 + q;
                res.val = asr32(sh_b5 + 32'd8, 4);
            end
        end
        else
        begin
            up = {8'd0, rd.raw} >> (8 - rd.oss);
            b1 = sext16(sh_bp[31:16]);
            b2 = sext16(sh_bp[15:0]);
            ac1 = sext16(sh_a1);
            ac2 = sext16(sh_a2);
            ac3 = sext16(sh_a3);
            b6 = sh_b5 - bpc_pkg::B6_OFFSET;
            sq = asr32(b6 * b6, 12);
            x1 = asr32(b2 * sq, 11);
            x2 = asr32(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = asr32(((ac1 * 32'd4 + x3) << rd.oss) + 32'd2, 2);
            x1 = asr32(ac3 * b6, 13);
            x2 = asr32(b1 * sq, 16);
            x3 = asr32(x1 + x2 + 32'd2, 2);
            b4 = ({16'd0, sh_a4} * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (bpc_pkg::P_SCALE >> rd.oss);
            if (b4 == 32'd0)
                res.fault = 1'b1;
            else
            begin
                if (!b7[31])
                    p = (b7 * 32'd2) / b4;
                else
                    p = (b7 / b4) * 32'd2;
                x1 = asr32(p, 8) * asr32(p, 8);
                x1 = asr32(x1 * bpc_pkg::K_SQ, 16);
                x2 = asr32(bpc_pkg::K_LIN * p, 16);
                res.val = p + asr32(x1 + x2 + bpc_pkg::K_OFS, 4);
            end
        end
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            raw_reading <= '0;
            oversampling <= '0;
            hold_cnt <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (hold_cnt > 0)
            begin
                in_valid <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (pending_readings.size() > 0)
            begin
                reading_t rd;
                rd = pending_readings.pop_front();
                expected_values.push_back(compensate(rd));
                in_valid <= 1'b1;
                kind <= rd.kind;
                raw_reading <= rd.raw;
                oversampling <= rd.oss;
                hold_cnt <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("unexpected result value=%0d", value);
                    errors++;
                end
                else
                begin
                    calib_t ex;
                    ex = expected_values.pop_front();
                    if (is_pressure !== ex.is_p)
                    begin
                        $error("is_pressure exp %0d got %0d", ex.is_p, is_pressure);
                        errors++;
                    end
                    if (value !== $signed(ex.val))
                    begin
                        $error("value exp %0d got %0d", $signed(ex.val), value);
                        errors++;
                    end
                    if (div_fault !== ex.fault)
                    begin
                        $error("div_fault exp %0d got %0d", ex.fault, div_fault);
                        errors++;
                    end
                end
            end
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                ready_hold <= out_valid ? gap_len() : 0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bpc_pkg::ADDR_A1: sh_a1 = data[15:0];
            bpc_pkg::ADDR_A2: sh_a2 = data[15:0];
            bpc_pkg::ADDR_A3: sh_a3 = data[15:0];
            bpc_pkg::ADDR_A4: sh_a4 = data[15:0];
            bpc_pkg::ADDR_A5: sh_a5 = data[15:0];
            bpc_pkg::ADDR_A6: sh_a6 = data[15:0];
            bpc_pkg::ADDR_BP: sh_bp = data;
            default:          sh_mp = data;
        endcase
    endtask

    // let every queued request drain, plus the block latency
    task automatic drain();
        while (pending_readings.size() > 0 || expected_values.size() > 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic push_reading(input logic k, input logic [23:0] r, input logic [1:0] o);
        reading_t rd;
        rd.kind = k;
        rd.raw = r;
        rd.oss = o;
        pending_readings.push_back(rd);
    endtask

    // mostly temperature then pressure pairs, with some random mix
    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                push_reading(1'b0, {8'($urandom_range(0, 255)),
                                    16'($urandom_range(20000, 40000))},
                             2'($urandom_range(0, 3)));
                push_reading(1'b1, 24'($urandom_range(0, 24'hFFFFFF)),
                             2'($urandom_range(0, 3)));
                i++;
            end
            else
                push_reading(1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)),
                             2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        errors = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sh_a1 = bpc_pkg::RST_A1;
        sh_a2 = bpc_pkg::RST_A2;
        sh_a3 = bpc_pkg::RST_A3;
        sh_a4 = bpc_pkg::RST_A4;
        sh_a5 = bpc_pkg::RST_A5;
        sh_a6 = bpc_pkg::RST_A6;
        sh_bp = bpc_pkg::RST_BP;
        sh_mp = bpc_pkg::RST_MP;
        sh_b5 = 32'd0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: pressure before any temperature, field extremes
        push_reading(1'b1, 24'h5D23A0, 2'd0);
        push_reading(1'b0, 24'h006C78, 2'd0);
        push_reading(1'b1, 24'h5D23A0, 2'd0);
        push_reading(1'b1, 24'hFFFFFF, 2'd3);
        push_reading(1'b1, 24'h000000, 2'd1);
        push_reading(1'b0, 24'hFFFFFF, 2'd3);
        push_reading(1'b0, 24'h000000, 2'd2);
        push_reading(1'b1, 24'hAAAAAA, 2'd2);
        push_reading(1'b1, 24'h555555, 2'd3);
        drain();

        // zero temperature divisor: ut = ac6 gives x1 = 0, and md = 0
        reg_write(bpc_pkg::ADDR_MP, 32'h12340000);
        push_reading(1'b0, {8'hFF, bpc_pkg::RST_A6}, 2'd1);
        push_reading(1'b1, 24'h5D23A0, 2'd1);
        drain();
        // zero pressure divisor: ac4 = 0
        reg_write(bpc_pkg::ADDR_A4, 32'd0);
        push_reading(1'b1, 24'h123456, 2'd0);
        drain();

        // calibration sweeps with extremes then random
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(bpc_pkg::ADDR_A1,
                      ph == 0 ? 32'h7FFF : (ph == 1 ? 32'h8000 : $urandom()));
            reg_write(bpc_pkg::ADDR_A2,
                      ph == 0 ? 32'h8000 : (ph == 1 ? 32'h7FFF : $urandom()));
            reg_write(bpc_pkg::ADDR_A3,
                      ph == 0 ? 32'h7FFF : (ph == 1 ? 32'h8000 : $urandom()));
            reg_write(bpc_pkg::ADDR_A4,
                      ph == 0 ? 32'hFFFF : (ph == 1 ? 32'h0001 : $urandom()));
            reg_write(bpc_pkg::ADDR_A5,
                      ph == 0 ? 32'hFFFF : (ph == 1 ? 32'h0000 : $urandom()));
            reg_write(bpc_pkg::ADDR_A6,
                      ph == 0 ? 32'h0000 : (ph == 1 ? 32'hFFFF : $urandom()));
            reg_write(bpc_pkg::ADDR_BP,
                      ph == 0 ? 32'h7FFF8000 : (ph == 1 ? 32'h80007FFF : $urandom()));
            reg_write(bpc_pkg::ADDR_MP,
                      ph == 0 ? 32'h80007FFF : (ph == 1 ? 32'h7FFF8000 : $urandom()));
            random_burst(ph < 2 ? 40 : 90);
            drain();
        end

        // back to factory calibration for the bulk
        reg_write(bpc_pkg::ADDR_A1, {16'd0, bpc_pkg::RST_A1});
        reg_write(bpc_pkg::ADDR_A2, {16'd0, bpc_pkg::RST_A2});
        reg_write(bpc_pkg::ADDR_A3, {16'd0, bpc_pkg::RST_A3});
        reg_write(bpc_pkg::ADDR_A4, {16'd0, bpc_pkg::RST_A4});
        reg_write(bpc_pkg::ADDR_A5, {16'd0, bpc_pkg::RST_A5});
        reg_write(bpc_pkg::ADDR_A6, {16'd0, bpc_pkg::RST_A6});
        reg_write(bpc_pkg::ADDR_BP, bpc_pkg::RST_BP);
        reg_write(bpc_pkg::ADDR_MP, bpc_pkg::RST_MP);
        random_burst(510);
        drain();
        random_burst(510);
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
